// ----- rtl/ldpm_pkg.sv -----
package ldpm_pkg;

    typedef logic signed [63:0] t_q;

    typedef enum logic [2:0] {
        CFG_FOCAL   = 3'd0,
        CFG_CENTER  = 3'd1,
        CFG_SKEW    = 3'd2,
        CFG_RAD_NUM = 3'd3,
        CFG_RAD_DEN = 3'd4,
        CFG_TANG    = 3'd5,
        CFG_PRISM   = 3'd6,
        CFG_BYPASS  = 3'd7
    } t_cfg_idx;

    localparam t_q LIM     = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam t_q ONE_Q32 = 64'sh0000_0001_0000_0000;
    localparam t_q S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam t_q S32_MIN = -64'sh0000_0000_8000_0000;

    localparam int MUL_LAT = 4;
    localparam int DIV_LAT = 65;

    // saturating add, operands within +-LIM
    function automatic t_q sadd(t_q a, t_q b);
        t_q s;
        s = a + b;
        if (s > LIM) begin
            sadd = LIM;
        end else if (s < -LIM) begin
            sadd = -LIM;
        end else begin
            sadd = s;
        end
    endfunction

    function automatic t_q sext32(logic [31:0] v);
        sext32 = {{32{v[31]}}, v};
    endfunction

    // Q4.16 -> Q.32
    function automatic t_q coef_k(logic [19:0] v);
        coef_k = {{28{v[19]}}, v, 16'h0000};
    endfunction

    // Q4.28 -> Q.32
    function automatic t_q coef_p(logic [31:0] v);
        coef_p = {{28{v[31]}}, v, 4'h0};
    endfunction

    // Q2.14 -> Q.32
    function automatic t_q coef_s(logic [15:0] v);
        coef_s = {{30{v[15]}}, v, 18'h00000};
    endfunction

    // {overflow, clamped 32-bit value}
    function automatic logic [32:0] sat32(t_q v);
        if (v > S32_MAX) begin
            sat32 = {1'b1, 32'h7FFF_FFFF};
        end else if (v < S32_MIN) begin
            sat32 = {1'b1, 32'h8000_0000};
        end else begin
            sat32 = {1'b0, v[31:0]};
        end
    endfunction

endpackage

// ----- rtl/ldpm_dly.sv -----
module ldpm_dly #(
    parameter int W = 64,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_pipe [0:N-1];

    always_ff @(posedge i_clk) begin
        r_pipe[0] <= i_d;
        for (int k = 1; k < N; k++) begin
            r_pipe[k] <= r_pipe[k-1];
        end
    end

    assign o_d = r_pipe[N-1];

endmodule

// ----- rtl/ldpm_smul.sv -----
module ldpm_smul import ldpm_pkg::*; (
    input  logic i_clk,
    input  t_q   i_a,
    input  t_q   i_b,
    output t_q   o_p
);

    logic        r_neg1, r_neg2, r_neg3;
    logic [61:0] r_ua, r_ub;
    logic [63:0] r_p00;
    logic [61:0] r_p01, r_p10;
    logic [59:0] r_p11;
    logic [61:0] r_mag;
    t_q          r_p;
    logic [64:0] n_sum;
    logic        n_sat;

    always_comb begin
        n_sum = 65'({r_p11[29:0], 32'h0000_0000}) + 65'(r_p01) + 65'(r_p10)
              + 65'(r_p00[63:32]) + 65'(r_p00[31]);
        n_sat = (r_p11[59:30] != 30'd0) || (n_sum > 65'(LIM));
    end

    always_ff @(posedge i_clk) begin
        // magnitudes and sign
        r_neg1 <= i_a[63] ^ i_b[63];
        r_ua   <= i_a[63] ? 62'(-i_a) : i_a[61:0];
        r_ub   <= i_b[63] ? 62'(-i_b) : i_b[61:0];
        // partial products
        r_neg2 <= r_neg1;
        r_p00  <= 64'(r_ua[31:0]) * 64'(r_ub[31:0]);
        r_p01  <= 62'(r_ua[31:0]) * 62'(r_ub[61:32]);
        r_p10  <= 62'(r_ua[61:32]) * 62'(r_ub[31:0]);
        r_p11  <= 60'(r_ua[61:32]) * 60'(r_ub[61:32]);
        // combine, round and clamp
        r_neg3 <= r_neg2;
        r_mag  <= n_sat ? LIM[61:0] : n_sum[61:0];
        // restore sign
        r_p    <= r_neg3 ? -t_q'({2'b00, r_mag}) : t_q'({2'b00, r_mag});
    end

    assign o_p = r_p;

endmodule

// ----- rtl/ldpm_sdiv.sv -----
module ldpm_sdiv import ldpm_pkg::*; (
    input  logic i_clk,
    input  t_q   i_n,
    input  t_q   i_d,
    output t_q   o_q
);

    localparam int QB = 62;

    logic [61:0] n_un, n_ud;
    logic [61:0] r_rem [0:QB];
    logic [61:0] r_dlo [0:QB];
    logic [61:0] r_qt  [0:QB];
    logic [61:0] r_ud  [0:QB];
    logic [1:0]  r_ctl [0:QB];   // {neg, sat}
    logic [62:0] r_qr;
    logic [1:0]  r_ctl_f;
    t_q          r_q;
    logic        n_rnd;

    always_comb begin
        n_un = i_n[63] ? 62'(-i_n) : i_n[61:0];
        n_ud = i_d[63] ? 62'(-i_d) : i_d[61:0];
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= {30'd0, n_un[61:30]};
        r_dlo[0] <= {n_un[29:0], 32'h0000_0000};
        r_qt[0]  <= '0;
        r_ud[0]  <= n_ud;
        // quotient would reach 2^62: clamp
        r_ctl[0] <= {i_n[63] ^ i_d[63],
                     {30'd0, n_un} >= {n_ud, 30'd0}};
    end

    for (genvar k = 0; k < QB; k++) begin : g_bit
        logic [62:0] n_rs;
        logic        n_ge;
        always_comb begin
            n_rs = {r_rem[k], r_dlo[k][QB-1]};
            n_ge = n_rs >= {1'b0, r_ud[k]};
        end
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_ge ? 62'(n_rs - {1'b0, r_ud[k]}) : n_rs[61:0];
            r_dlo[k+1] <= {r_dlo[k][QB-2:0], 1'b0};
            r_qt[k+1]  <= {r_qt[k][QB-2:0], n_ge};
            r_ud[k+1]  <= r_ud[k];
            r_ctl[k+1] <= r_ctl[k];
        end
    end

    assign n_rnd = {r_rem[QB], 1'b0} >= {1'b0, r_ud[QB]};

    always_ff @(posedge i_clk) begin
        r_qr    <= 63'(r_qt[QB]) + 63'(n_rnd);
        r_ctl_f <= r_ctl[QB];
        if (r_ctl_f[0] || (r_qr > 63'(LIM))) begin
            r_q <= r_ctl_f[1] ? -LIM : LIM;
        end else begin
            r_q <= r_ctl_f[1] ? -t_q'({1'b0, r_qr}) : t_q'({1'b0, r_qr});
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/lens_distortion_point_map_top.sv -----
// o_valid follows the edge that takes start through three pipelined dividers,
//   seven multiplier ranks and ten register stages.
// Throughput: one point per clock; busy stays low, points may arrive every cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active low) clears the valid pipeline and loads the
//   register defaults (unit focal lengths, bypass on).
module lens_distortion_point_map_top import ldpm_pkg::*; #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_valid,
    output logic [31:0] o_warped_x,
    output logic [31:0] o_warped_y,
    output logic        o_overflow,
    output logic        o_divide_fault
);

    localparam logic [31:0] ONE_PX = 32'd1 << COORD_FRAC_BITS;

    localparam int LD   = DIV_LAT;
    localparam int LM   = MUL_LAT;
    localparam int C_Y  = 1 + LD;
    localparam int C_N  = C_Y + LM + 1;
    localparam int C_X  = C_N + LD;
    localparam int C_P  = C_X + LM;
    localparam int C_A  = C_P + 1;
    localparam int C_R4 = C_A + LM;
    localparam int C_R6 = C_R4 + LM;
    localparam int C_K  = C_R6 + LM;
    localparam int C_Q  = C_K + 2;
    localparam int C_D  = C_Q + LD;
    localparam int C_M  = C_D + LM;
    localparam int C_E  = C_M + 3;
    localparam int C_F  = C_E + LM;
    localparam int C_W  = C_F + 1;

    // coefficient product lanes
    localparam int NK   = 14;
    localparam int P_K1 = 0;
    localparam int P_K2 = 1;
    localparam int P_K3 = 2;
    localparam int P_K4 = 3;
    localparam int P_K5 = 4;
    localparam int P_K6 = 5;
    localparam int P_S1 = 6;
    localparam int P_S2 = 7;
    localparam int P_S3 = 8;
    localparam int P_S4 = 9;
    localparam int P_P1XY = 10;
    localparam int P_P2XY = 11;
    localparam int P_P2TX = 12;
    localparam int P_P1TY = 13;

    logic [63:0] r_focal, r_center, r_tang, r_prism;
    logic [31:0] r_skew;
    logic [59:0] r_knum, r_kden;
    logic        r_bypass;

    t_q fx, fy, cx, cy, sk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal  <= {ONE_PX, ONE_PX};
            r_center <= '0;
            r_skew   <= '0;
            r_knum   <= '0;
            r_kden   <= '0;
            r_tang   <= '0;
            r_prism  <= '0;
            r_bypass <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FOCAL:   r_focal  <= i_cfg_data;
                CFG_CENTER:  r_center <= i_cfg_data;
                CFG_SKEW:    r_skew   <= i_cfg_data[31:0];
                CFG_RAD_NUM: r_knum   <= i_cfg_data[59:0];
                CFG_RAD_DEN: r_kden   <= i_cfg_data[59:0];
                CFG_TANG:    r_tang   <= i_cfg_data;
                CFG_PRISM:   r_prism  <= i_cfg_data;
                CFG_BYPASS:  r_bypass <= i_cfg_data[0];
                default:     r_bypass <= r_bypass;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    assign fx = t_q'({32'h0, r_focal[31:0]});
    assign fy = t_q'({32'h0, r_focal[63:32]});
    assign cx = sext32(r_center[31:0]);
    assign cy = sext32(r_center[63:32]);
    assign sk = sext32(r_skew);

    // valid pipeline
    logic r_vld [1:C_W];
    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= C_W; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else begin
            r_vld[1] <= start;
            for (int k = 2; k <= C_W; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[C_W];
        end
    end

    // center offsets
    t_q          r_dx, r_dy;
    logic [31:0] r_px, r_py;
    logic        r_flt0;

    always_ff @(posedge i_clk) begin
        r_dx   <= sext32(i_point_x) - cx;
        r_dy   <= sext32(i_point_y) - cy;
        r_px   <= i_point_x;
        r_py   <= i_point_y;
        r_flt0 <= (fx == 64'sd0) || (fy == 64'sd0);
    end

    // normalize y, then x with the skew correction
    t_q yn, dx_n, skyn, r_numx, xn, yn_x;

    ldpm_sdiv u_div_y (.i_clk(i_clk), .i_n(r_dy), .i_d(fy), .o_q(yn));
    ldpm_dly #(.W(64), .N(C_Y + LM - 1)) u_dly_dx (.i_clk(i_clk), .i_d(r_dx), .o_d(dx_n));
    ldpm_smul u_mul_skyn (.i_clk(i_clk), .i_a(sk), .i_b(yn), .o_p(skyn));

    always_ff @(posedge i_clk) begin
        r_numx <= sadd(dx_n, -skyn);
    end

    ldpm_sdiv u_div_x (.i_clk(i_clk), .i_n(r_numx), .i_d(fx), .o_q(xn));
    ldpm_dly #(.W(64), .N(C_X - C_Y)) u_dly_yn (.i_clk(i_clk), .i_d(yn), .o_d(yn_x));

    // squares and cross term
    t_q xx, yy, xy;
    t_q r_r2, r_xy2, r_xx2, r_yy2, r_tx, r_ty;

    ldpm_smul u_mul_xx (.i_clk(i_clk), .i_a(xn),   .i_b(xn),   .o_p(xx));
    ldpm_smul u_mul_yy (.i_clk(i_clk), .i_a(yn_x), .i_b(yn_x), .o_p(yy));
    ldpm_smul u_mul_xy (.i_clk(i_clk), .i_a(xn),   .i_b(yn_x), .o_p(xy));

    always_ff @(posedge i_clk) begin
        r_r2  <= sadd(xx, yy);
        r_xy2 <= sadd(xy, xy);
        r_xx2 <= sadd(xx, xx);
        r_yy2 <= sadd(yy, yy);
        r_tx  <= sadd(r_r2, r_xx2);
        r_ty  <= sadd(r_r2, r_yy2);
    end

    // radial powers
    t_q r4, r6, r2_4, r2_6, r4_6, xy_6, tx_6, ty_6;

    ldpm_smul u_mul_r4 (.i_clk(i_clk), .i_a(r_r2), .i_b(r_r2), .o_p(r4));
    ldpm_dly #(.W(64), .N(LM)) u_dly_r2a (.i_clk(i_clk), .i_d(r_r2), .o_d(r2_4));
    ldpm_smul u_mul_r6 (.i_clk(i_clk), .i_a(r4), .i_b(r2_4), .o_p(r6));
    ldpm_dly #(.W(64), .N(LM)) u_dly_r2b (.i_clk(i_clk), .i_d(r2_4), .o_d(r2_6));
    ldpm_dly #(.W(64), .N(LM)) u_dly_r4 (.i_clk(i_clk), .i_d(r4), .o_d(r4_6));
    ldpm_dly #(.W(64), .N(2 * LM)) u_dly_xy (.i_clk(i_clk), .i_d(r_xy2), .o_d(xy_6));
    ldpm_dly #(.W(128), .N(2 * LM - 1)) u_dly_t (
        .i_clk(i_clk), .i_d({r_tx, r_ty}), .o_d({tx_6, ty_6})
    );

    // coefficient products, all in one rank
    t_q ka [0:NK-1];
    t_q kb [0:NK-1];
    t_q kp [0:NK-1];

    always_comb begin
        ka[P_K1]   = coef_k(r_knum[19:0]);   kb[P_K1]   = r2_6;
        ka[P_K2]   = coef_k(r_knum[39:20]);  kb[P_K2]   = r4_6;
        ka[P_K3]   = coef_k(r_knum[59:40]);  kb[P_K3]   = r6;
        ka[P_K4]   = coef_k(r_kden[19:0]);   kb[P_K4]   = r2_6;
        ka[P_K5]   = coef_k(r_kden[39:20]);  kb[P_K5]   = r4_6;
        ka[P_K6]   = coef_k(r_kden[59:40]);  kb[P_K6]   = r6;
        ka[P_S1]   = coef_s(r_prism[15:0]);  kb[P_S1]   = r2_6;
        ka[P_S2]   = coef_s(r_prism[31:16]); kb[P_S2]   = r4_6;
        ka[P_S3]   = coef_s(r_prism[47:32]); kb[P_S3]   = r2_6;
        ka[P_S4]   = coef_s(r_prism[63:48]); kb[P_S4]   = r4_6;
        ka[P_P1XY] = coef_p(r_tang[31:0]);   kb[P_P1XY] = xy_6;
        ka[P_P2XY] = coef_p(r_tang[63:32]);  kb[P_P2XY] = xy_6;
        ka[P_P2TX] = coef_p(r_tang[63:32]);  kb[P_P2TX] = tx_6;
        ka[P_P1TY] = coef_p(r_tang[31:0]);   kb[P_P1TY] = ty_6;
    end

    for (genvar g = 0; g < NK; g++) begin : g_coef
        ldpm_smul u_mul (.i_clk(i_clk), .i_a(ka[g]), .i_b(kb[g]), .o_p(kp[g]));
    end

    // rational term
    t_q r_na, r_nb, r_da, r_db, r_sx, r_sy, r_num, r_den;

    always_ff @(posedge i_clk) begin
        r_na  <= sadd(ONE_Q32, kp[P_K1]);
        r_nb  <= sadd(kp[P_K2], kp[P_K3]);
        r_da  <= sadd(ONE_Q32, kp[P_K4]);
        r_db  <= sadd(kp[P_K5], kp[P_K6]);
        r_sx  <= sadd(kp[P_S1], kp[P_S2]);
        r_sy  <= sadd(kp[P_S3], kp[P_S4]);
        r_num <= sadd(r_na, r_nb);
        r_den <= sadd(r_da, r_db);
    end

    t_q   dq, xn_d, yn_d, xnd, ynd;
    logic dz_w;

    ldpm_sdiv u_div_d (.i_clk(i_clk), .i_n(r_num), .i_d(r_den), .o_q(dq));
    ldpm_dly #(.W(64), .N(C_D - C_X)) u_dly_xn (.i_clk(i_clk), .i_d(xn), .o_d(xn_d));
    ldpm_dly #(.W(64), .N(C_D - C_X)) u_dly_yn2 (.i_clk(i_clk), .i_d(yn_x), .o_d(yn_d));
    ldpm_dly #(.W(1), .N(C_W - C_Q)) u_dly_dz (
        .i_clk(i_clk), .i_d(r_den == 64'sd0), .o_d(dz_w)
    );

    ldpm_smul u_mul_xd (.i_clk(i_clk), .i_a(xn_d), .i_b(dq), .o_p(xnd));
    ldpm_smul u_mul_yd (.i_clk(i_clk), .i_a(yn_d), .i_b(dq), .o_p(ynd));

    // tangential and prism terms, aligned to the adds below
    t_q p1xy_m, p2xy_m, p2tx_m, p1ty_m, sx_m, sy_m;

    ldpm_dly #(.W(128), .N(C_M - C_K)) u_dly_pxy (
        .i_clk(i_clk), .i_d({kp[P_P1XY], kp[P_P2XY]}), .o_d({p1xy_m, p2xy_m})
    );
    ldpm_dly #(.W(128), .N(C_M + 1 - C_K)) u_dly_pt (
        .i_clk(i_clk), .i_d({kp[P_P2TX], kp[P_P1TY]}), .o_d({p2tx_m, p1ty_m})
    );
    ldpm_dly #(.W(128), .N(C_M + 1 - C_K)) u_dly_s (
        .i_clk(i_clk), .i_d({r_sx, r_sy}), .o_d({sx_m, sy_m})
    );

    t_q r_xd1, r_yd1, r_xd2, r_yd2, r_xd, r_yd;

    // keep the accumulation order: saturating adds do not reassociate
    always_ff @(posedge i_clk) begin
        r_xd1 <= sadd(xnd, p1xy_m);
        r_yd1 <= sadd(ynd, p2xy_m);
        r_xd2 <= sadd(r_xd1, p2tx_m);
        r_yd2 <= sadd(r_yd1, p1ty_m);
        r_xd  <= sadd(r_xd2, sx_m);
        r_yd  <= sadd(r_yd2, sy_m);
    end

    // back to pixels
    t_q xdfx, ydsk, ydfy, r_wx1, r_wy;

    ldpm_smul u_mul_fx (.i_clk(i_clk), .i_a(r_xd), .i_b(fx), .o_p(xdfx));
    ldpm_smul u_mul_sk (.i_clk(i_clk), .i_a(r_yd), .i_b(sk), .o_p(ydsk));
    ldpm_smul u_mul_fy (.i_clk(i_clk), .i_a(r_yd), .i_b(fy), .o_p(ydfy));

    always_ff @(posedge i_clk) begin
        r_wx1 <= sadd(xdfx, ydsk);
        r_wy  <= sadd(ydfy, cy);
    end

    logic [31:0] px_w, py_w;
    logic        flt0_w;

    ldpm_dly #(.W(65), .N(C_W - 1)) u_dly_in (
        .i_clk(i_clk), .i_d({r_flt0, r_px, r_py}), .o_d({flt0_w, px_w, py_w})
    );

    logic [32:0] n_sx, n_sy;
    logic [31:0] r_ox, r_oy;
    logic        r_oovf, r_oflt;

    always_comb begin
        n_sx = sat32(sadd(r_wx1, cx));
        n_sy = sat32(r_wy);
    end

    always_ff @(posedge i_clk) begin
        if (r_bypass) begin
            r_ox   <= px_w;
            r_oy   <= py_w;
            r_oovf <= 1'b0;
            r_oflt <= 1'b0;
        end else if (flt0_w || dz_w) begin
            r_ox   <= 32'h7FFF_FFFF;
            r_oy   <= 32'h7FFF_FFFF;
            r_oovf <= 1'b1;
            r_oflt <= 1'b1;
        end else begin
            r_ox   <= n_sx[31:0];
            r_oy   <= n_sy[31:0];
            r_oovf <= n_sx[32] | n_sy[32];
            r_oflt <= 1'b0;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_warped_x     = r_ox;
    assign o_warped_y     = r_oy;
    assign o_overflow     = r_oovf;
    assign o_divide_fault = r_oflt;

`ifndef ASSERT_OFF
    a_fault_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_fault |-> o_overflow)
        else $error("divide fault without overflow");

    a_fault_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_fault |->
            (o_warped_x == 32'h7FFF_FFFF) && (o_warped_y == 32'h7FFF_FFFF))
        else $error("divide fault result not saturated high");

    a_ovf_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow && !o_divide_fault |->
            (o_warped_x == 32'h7FFF_FFFF) || (o_warped_x == 32'h8000_0000) ||
            (o_warped_y == 32'h7FFF_FFFF) || (o_warped_y == 32'h8000_0000))
        else $error("overflow flagged without a clamped coordinate");
`endif

endmodule
